>>> rtl/core/mfbp_pkg.sv
package mfbp_pkg;

	localparam int unsigned BYTE_BITS  = 8;
	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned COUNT_BITS = 6;

	typedef logic [BYTE_BITS-1:0]  byte_t;
	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [COUNT_BITS-1:0] count_t;

endpackage

>>> rtl/core/mfbp_intf.sv
interface mfbp_field_if;
	logic                valid;
	logic                ready;
	mfbp_pkg::value_t    field_value;
	mfbp_pkg::count_t    bit_count;
	logic                flush_after;

	modport source (output valid, output field_value, output bit_count, output flush_after,
		input ready);
	modport sink (input valid, input field_value, input bit_count, input flush_after,
		output ready);
endinterface

interface mfbp_byte_if;
	logic                valid;
	logic                ready;
	mfbp_pkg::byte_t     out_byte;
	logic                last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> rtl/core/msb_first_bit_packer_unit.sv
// Packs fields of up to MAX_FIELD_BITS bits into a byte stream, first bit in bit 7 of
// each byte. The front aligns and queues an item in the cycle it is accepted, so up to
// two items wait while the back works; the back first loads an item and then works
// through the field one chunk per cycle, a chunk ending at a byte boundary or at the
// field's end, while the output is not stalled. There is a single output register,
// and a stalled output stalls only the back.
module msb_first_bit_packer_unit #(
	parameter int unsigned MAX_FIELD_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	mfbp_field_if.sink  field_ch,
	mfbp_byte_if.source byte_ch
);
	import mfbp_pkg::*;

	localparam int unsigned CW = $clog2(MAX_FIELD_BITS + 1);
	localparam int unsigned DW = MAX_FIELD_BITS + CW + 1;

	logic          q_full;
	logic          push;
	logic [DW-1:0] push_data;
	logic          pop;
	logic          q_valid;
	logic [DW-1:0] q_data;

	mfbp_front #(.W(MAX_FIELD_BITS), .CW(CW), .DW(DW)) u_front (
		.fields    (field_ch),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	mfbp_queue #(.DW(DW)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.valid     (q_valid),
		.pop_data  (q_data)
	);

	mfbp_back #(.W(MAX_FIELD_BITS), .CW(CW), .DW(DW)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.pop     (pop),
		.bytes   (byte_ch)
	);

endmodule

>>> rtl/core/mfbp_front.sv
module mfbp_front #(
	parameter int unsigned W  = 32,
	parameter int unsigned CW = 6,
	parameter int unsigned DW = W + CW + 1
) (
	mfbp_field_if.sink   fields,
	input  logic         q_full,
	output logic         push,
	output logic [DW-1:0] push_data
);
	import mfbp_pkg::*;

	localparam logic [6:0] W7 = 7'(W);

	logic [6:0]              bc_ext;
	logic [6:0]              sat;
	logic [6:0]              sh;
	logic [W+VALUE_BITS-1:0] ext;
	logic [W+VALUE_BITS-1:0] shifted;

	// Saturate the count and left-align the field so its first bit sits at the top.
	always_comb begin
		bc_ext  = {1'b0, fields.bit_count};
		sat     = (bc_ext > W7) ? W7 : bc_ext;
		sh      = W7 - sat;
		ext     = {{W{1'b0}}, fields.field_value};
		shifted = ext << sh;
	end

	assign fields.ready = !q_full;
	assign push         = fields.valid && !q_full;
	assign push_data    = {shifted[W-1:0], CW'(sat), fields.flush_after};

endmodule

>>> rtl/core/mfbp_queue.sv
module mfbp_queue #(
	parameter int unsigned DW = 39
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] push_data,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output logic [DW-1:0] pop_data
);
	logic [DW-1:0] mem_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	assign full     = cnt_q[1];
	assign valid    = cnt_q != 2'd0;
	assign pop_data = mem_q[rd_q];

endmodule

>>> rtl/core/mfbp_back.sv
module mfbp_back #(
	parameter int unsigned W  = 32,
	parameter int unsigned CW = 6,
	parameter int unsigned DW = W + CW + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  logic [DW-1:0] q_data,
	output logic          pop,
	mfbp_byte_if.source   bytes
);
	import mfbp_pkg::*;

	localparam int unsigned XW = (CW > 4) ? CW : 4;

	logic          act_q;
	logic [W-1:0]  a_q;
	logic [CW-1:0] rem_q;
	logic          flush_q;
	byte_t         pbits_q;
	logic [2:0]    pcnt_q;
	logic          ov_q;
	byte_t         byte_q;
	logic          last_q;

	logic [3:0]    room;
	logic [XW-1:0] take_x;
	logic [3:0]    take;
	logic [W+7:0]  win;
	byte_t         merged;
	logic [3:0]    new_cnt;
	logic [CW-1:0] rem_next;
	logic          full;
	logic          emit;
	logic          can;
	logic          step;
	logic          last;

	always_comb begin
		room     = 4'(BYTE_BITS) - {1'b0, pcnt_q};
		take_x   = (XW'(rem_q) < XW'(room)) ? XW'(rem_q) : XW'(room);
		take     = take_x[3:0];
		win      = {a_q, 8'b0};
		merged   = pbits_q | (win[W+7:W] >> pcnt_q);
		new_cnt  = {1'b0, pcnt_q} + take;
		rem_next = rem_q - CW'(take);
		full     = new_cnt[3];
		// A partial byte only goes out when the field is used up and a flush was asked for.
		emit     = act_q && (full || (flush_q && new_cnt != 4'd0));
		can      = !ov_q || bytes.ready;
		step     = act_q && (!emit || can);
		// A short tail left without a flush stays pending, so this full byte is the last.
		last     = !full || (rem_next == '0) ||
			((XW'(rem_next) < XW'(BYTE_BITS)) && !flush_q);
	end

	assign pop = !act_q && q_valid;

	always_ff @(posedge clk) begin
		if (pop) begin
			a_q     <= q_data[DW-1 -: W];
			rem_q   <= q_data[CW:1];
			flush_q <= q_data[0];
		end else if (step) begin
			a_q     <= a_q << take;
			rem_q   <= rem_next;
		end
		if (can) begin
			byte_q <= merged;
			last_q <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= 1'b0;
			pbits_q <= '0;
			pcnt_q  <= 3'd0;
			ov_q    <= 1'b0;
		end else begin
			if (pop) begin
				act_q <= 1'b1;
			end else if (step && rem_next == '0) begin
				act_q <= 1'b0;
			end
			if (step) begin
				if (emit) begin
					pbits_q <= '0;
					pcnt_q  <= 3'd0;
				end else begin
					pbits_q <= merged;
					pcnt_q  <= new_cnt[2:0];
				end
			end
			if (can) begin
				ov_q <= emit;
			end
		end
	end

	assign bytes.valid       = ov_q;
	assign bytes.out_byte    = byte_q;
	assign bytes.last_of_run = last_q;

endmodule

>>> rtl/core/mfbp_checker.sv
module mfbp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input mfbp_pkg::byte_t     out_byte,
	input logic                last_of_run
);
	import mfbp_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(last_of_run))
		else $error("stalled result item changed");

	// Bytes of one item leave back to back once the sink takes them.
	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a run of bytes");

	a_ready_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(arst_n) |-> in_ready)
		else $error("input not ready after reset");

endmodule

bind msb_first_bit_packer_unit mfbp_checker u_mfbp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (field_ch.ready),
	.out_valid   (byte_ch.valid),
	.out_ready   (byte_ch.ready),
	.out_byte    (byte_ch.out_byte),
	.last_of_run (byte_ch.last_of_run)
);

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import mfbp_pkg::*;

	localparam int unsigned FIELD_LIMIT  = 32;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned TAIL_CYCLES  = 20;
	localparam int unsigned HOLD_CYCLES  = 250;
	localparam int unsigned RANDOM_ITEMS = 440;

	typedef struct packed {
		byte_t out_byte;
		logic  last_of_run;
	} byte_result_t;

	// Keeps its own copy of the partial byte and predicts the byte stream.
	class packed_byte_scoreboard;
		byte_result_t expected_bytes[$];
		byte_t        partial_byte;
		int unsigned  partial_count;
		int unsigned  mismatches;

		function new();
			partial_byte  = '0;
			partial_count = 0;
			mismatches    = 0;
		endfunction

		function void push_byte();
			byte_result_t entry;
			entry.out_byte    = partial_byte;
			entry.last_of_run = 1'b0;
			expected_bytes.push_back(entry);
			partial_byte  = '0;
			partial_count = 0;
		endfunction

		function void note_field(value_t value, count_t count, logic flush);
			int unsigned n;
			int unsigned emitted;
			int          k;
			n = (count > FIELD_LIMIT) ? FIELD_LIMIT : count;
			emitted = 0;
			for (k = int'(n) - 1; k >= 0; k--) begin
				partial_byte[BYTE_BITS-1-partial_count] = (k < VALUE_BITS) ? value[k] : 1'b0;
				partial_count++;
				if (partial_count == BYTE_BITS) begin
					push_byte();
					emitted++;
				end
			end
			if (flush && partial_count != 0) begin
				push_byte();
				emitted++;
			end
			if (emitted != 0)
				expected_bytes[$].last_of_run = 1'b1;
		endfunction

		function void check_byte(byte_t out_byte, logic last_of_run);
			byte_result_t want;
			if (expected_bytes.size() == 0) begin
				$error("unexpected item: out_byte %02h last_of_run %0b", out_byte, last_of_run);
				mismatches++;
				return;
			end
			want = expected_bytes.pop_front();
			if (out_byte !== want.out_byte) begin
				$error("out_byte mismatch: expected %02h, actual %02h", want.out_byte, out_byte);
				mismatches++;
			end
			if (last_of_run !== want.last_of_run) begin
				$error("last_of_run mismatch: expected %0b, actual %0b",
					want.last_of_run, last_of_run);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mfbp_field_if field_ch();
	mfbp_byte_if  byte_ch();

	msb_first_bit_packer_unit #(
		.MAX_FIELD_BITS(FIELD_LIMIT)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.field_ch(field_ch),
		.byte_ch (byte_ch)
	);

	packed_byte_scoreboard byte_sb = new();

	bit          long_stall_req = 1'b0;
	int unsigned burst_left     = 0;
	int unsigned cycle_count    = 0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Both monitors sample at the edge, before the block's registers update.
	always @(posedge clk) begin
		if (arst_n && field_ch.valid && field_ch.ready)
			byte_sb.note_field(field_ch.field_value, field_ch.bit_count, field_ch.flush_after);
		if (arst_n && byte_ch.valid && byte_ch.ready)
			byte_sb.check_byte(byte_ch.out_byte, byte_ch.last_of_run);
	end

	initial begin : byte_sink
		int unsigned hold_left;
		int unsigned mode;
		int unsigned mode_left;
		int unsigned tick;
		hold_left = 0;
		mode      = 0;
		mode_left = 0;
		tick      = 0;
		byte_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			tick++;
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				mode      = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				byte_ch.ready <= 1'b0;
			end else begin
				case (mode)
					0: byte_ch.ready <= 1'b1;
					1: byte_ch.ready <= 1'($urandom_range(0, 1));
					2: byte_ch.ready <= (tick % 4 == 0);
					default: byte_ch.ready <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	// Holds the item until the block takes it; returns at the accepting edge.
	task automatic offer_field(input value_t value, input count_t count, input logic flush);
		field_ch.valid       <= 1'b1;
		field_ch.field_value <= value;
		field_ch.bit_count   <= count;
		field_ch.flush_after <= flush;
		do @(posedge clk); while (!field_ch.ready);
	endtask

	task automatic send_field(input value_t value, input count_t count, input logic flush);
		int unsigned gap;
		offer_field(value, count, flush);
		if (burst_left != 0)
			burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				field_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// The extra edge lets the monitor note the item accepted at the previous edge.
	task automatic wait_for_drain();
		field_ch.valid <= 1'b0;
		@(posedge clk);
		while (byte_sb.expected_bytes.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		value_t      value;
		count_t      count;
		logic        flush;
		int unsigned pick;
		int unsigned i;

		arst_n               = 1'b0;
		field_ch.valid       = 1'b0;
		field_ch.field_value = '0;
		field_ch.bit_count   = '0;
		field_ch.flush_after = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty appends and a flush with nothing pending cause no byte.
		send_field(32'hFFFF_FFFF, 6'd0, 1'b0);
		send_field(32'h0000_0000, 6'd0, 1'b1);
		send_field(32'hFFFF_FFFF, 6'd32, 1'b0);
		send_field(32'h0000_0000, 6'd32, 1'b0);
		send_field(32'hA5C3_0F96, 6'd63, 1'b0);
		send_field(32'h1234_5678, 6'd33, 1'b1);
		send_field(32'h0000_0001, 6'd1, 1'b1);
		send_field(32'hFFFF_FFF5, 6'd3, 1'b0);
		send_field(32'h1357_9BDF, 6'd29, 1'b0);
		// Seven pending bits plus a full field and a flush give five bytes.
		send_field(32'h0000_007F, 6'd7, 1'b0);
		send_field(32'hDEAD_BEEF, 6'd32, 1'b1);
		send_field(32'hFFFF_FFFF, 6'd4, 1'b0);
		send_field(32'h0000_0000, 6'd0, 1'b1);
		send_field(32'h0000_00C3, 6'd8, 1'b0);
		send_field(32'h0000_5AA5, 6'd16, 1'b1);
		send_field(32'h00F0_0F0F, 6'd24, 1'b0);
		send_field(32'h8000_0000, 6'd32, 1'b1);
		send_field(32'h7FFF_FFFF, 6'd31, 1'b1);
		send_field(32'hFFFF_FFFF, 6'd48, 1'b1);
		send_field(32'h0000_0002, 6'd2, 1'b0);
		send_field(32'h0000_0000, 6'd0, 1'b0);
		send_field(32'h0000_0001, 6'd5, 1'b1);

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 120)
				long_stall_req = 1'b1;
			if (i == 300)
				wait_for_drain();
			value = $urandom;
			pick  = $urandom_range(0, 99);
			if (pick < 5)
				count = 6'd0;
			else if (pick < 12)
				count = 6'($urandom_range(33, 63));
			else if (pick < 25)
				count = 6'd32;
			else
				count = 6'($urandom_range(1, 31));
			flush = ($urandom_range(0, 5) == 0);
			send_field(value, count, flush);
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (byte_sb.expected_bytes.size() != 0)
			$error("%0d expected bytes never arrived", byte_sb.expected_bytes.size());
		if (byte_sb.mismatches == 0 && byte_sb.expected_bytes.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
